/* rtl/core/seven_segment_scan_with_bcd_macros.svh */
// Assertion macros used by the display driver top level.
`ifndef SEVEN_SEGMENT_SCAN_WITH_BCD_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_WITH_BCD_MACROS_SVH

`ifndef SYNTH
`define SSD_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("display driver check failed");
`define SSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("display driver check failed");
`define SSD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("display driver check failed");
`else
`define SSD_ASSERT_ALWAYS(label, clk, rst, expr)
`define SSD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/ssd_pkg.sv */
// Types and constants of the multiplexed seven-segment display driver.
`timescale 1ns / 1ps
package ssd_pkg;

  localparam int DIGITS = 4;
  localparam int CODE_W = 8;

  localparam logic [CODE_W-1:0] BLANK_CODE = 8'h0F;
  localparam logic [CODE_W-1:0] CODE_LIMIT = 8'd10;

  localparam logic [CODE_W-1:0] RESET_CODES [DIGITS] = '{8'd1, 8'd3, 8'd5, 8'd6};

  // x / 10 == (x * 0xCCCD) >> 19 for any 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_RAW  = 2'd1,
    MODE_BIN  = 2'd2
  } mode_t;

  typedef struct packed {
    logic tick;      // pass the scan token to the next cell
    logic load_raw;  // take the raw code
    logic shift;     // take the code of the upper neighbor
    logic blank;     // blank a leading zero
  } cell_ctrl_t;

endpackage

/* rtl/core/seven_segment_scan_with_bcd.sv */
// Top level: four-digit multiplexed display driver with binary-to-decimal load.
// A refresh tick gives its result in the cycle after the transfer.
// A raw digit load gives no result. One tick per cycle while idle and the output free.
// A binary load stalls the input during 4 divide-by-ten steps, which shift digits
// through the digit cells, and then during one leading-zero blanking step.
// Synchronous reset: codes 1, 3, 5, 6, scan at position 0, port latch 0, output empty.
`timescale 1ns / 1ps
module seven_segment_scan_with_bcd (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // value[15:0], digit_a, digit_b, digit_c, digit_d
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // port_value
  output logic [0:0]  m_tuser    // port_updated
);
  import ssd_pkg::*;

  `include "seven_segment_scan_with_bcd_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_BLANK
  } state_t;

  state_t      state;
  logic [7:0]  port_latch;

  logic        in_xfer;
  logic        is_tick;
  logic        is_raw;
  logic        is_bin;
  logic        bcd_shift;
  logic        bcd_last;
  logic [3:0]  bcd_digit;
  cell_ctrl_t  ctrl;

  logic [CODE_W-1:0] code     [DIGITS];
  logic [CODE_W-1:0] sel_code [DIGITS];
  logic [DIGITS-1:0] tok;
  logic [DIGITS:0]   zero_above;
  logic [CODE_W-1:0] cur_code;
  logic              write;
  logic [7:0]        latch_next;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign in_xfer  = s_tvalid && s_tready;
  assign is_tick  = in_xfer && (s_tuser == MODE_TICK);
  assign is_raw   = in_xfer && (s_tuser == MODE_RAW);
  assign is_bin   = in_xfer && (s_tuser == MODE_BIN);

  assign ctrl.tick     = is_tick;
  assign ctrl.load_raw = is_raw;
  assign ctrl.shift    = bcd_shift;
  assign ctrl.blank    = (state == S_BLANK);

  ssd_bcd_step u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (is_bin),
    .value (s_tdata[15:0]),
    .shift (bcd_shift),
    .last  (bcd_last),
    .digit (bcd_digit)
  );

  assign zero_above[DIGITS] = 1'b1;

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    logic [CODE_W-1:0] shift_in;
    if (i == DIGITS - 1) begin : g_top
      assign shift_in = {4'b0000, bcd_digit};
    end else begin : g_mid
      assign shift_in = code[i+1];
    end
    ssd_cell #(
      .Index (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .raw_code       (s_tdata[16 + CODE_W*i +: CODE_W]),
      .shift_in       (shift_in),
      .tok_in         (tok[(i + DIGITS - 1) % DIGITS]),
      .zero_above_in  (zero_above[i+1]),
      .code           (code[i]),
      .sel_code       (sel_code[i]),
      .tok            (tok[i]),
      .zero_above_out (zero_above[i])
    );
  end

  assign cur_code   = sel_code[0] | sel_code[1] | sel_code[2] | sel_code[3];
  assign write      = (cur_code < CODE_LIMIT);
  assign latch_next = write ? {tok, cur_code[3:0]} : port_latch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      port_latch <= 8'd0;
      m_tvalid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (is_bin) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (bcd_last) begin
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (is_tick) begin
        port_latch <= latch_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      m_tdata    <= latch_next;
      m_tuser[0] <= write;
    end
  end

  `SSD_ASSERT_ALWAYS(a_tok_onehot, clk, rst, $onehot(tok))
  `SSD_ASSERT_ALWAYS(a_latch_sel, clk, rst, $onehot0(port_latch[7:4]))
  `SSD_ASSERT_IMP(a_busy_stall, clk, rst, state != S_IDLE, !s_tready)
  `SSD_ASSERT_NXT(a_tick_result, clk, rst, is_tick, m_tvalid && (m_tdata == port_latch))
  `SSD_ASSERT_NXT(a_conv_blank, clk, rst, bcd_last, state == S_BLANK)

endmodule

/* rtl/core/ssd_cell.sv */
// One digit cell: holds a code and the scan token, shifts toward position 0.
`timescale 1ns / 1ps
module ssd_cell #(
  parameter int Index = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ssd_pkg::cell_ctrl_t       ctrl,
  input  logic [ssd_pkg::CODE_W-1:0] raw_code,
  input  logic [ssd_pkg::CODE_W-1:0] shift_in,
  input  logic                      tok_in,
  input  logic                      zero_above_in,
  output logic [ssd_pkg::CODE_W-1:0] code,
  output logic [ssd_pkg::CODE_W-1:0] sel_code,
  output logic                      tok,
  output logic                      zero_above_out
);
  import ssd_pkg::*;

  localparam logic [CODE_W-1:0] ResetCode = RESET_CODES[Index];
  localparam bit TokenInit = (Index == 0);
  localparam bit CanBlank  = (Index != 0);

  logic is_zero;

  assign is_zero        = (code == '0);
  assign zero_above_out = zero_above_in & is_zero;
  assign sel_code       = tok ? code : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      code <= ResetCode;
      tok  <= TokenInit;
    end else begin
      if (ctrl.tick) begin
        tok <= tok_in;
      end
      if (ctrl.load_raw) begin
        code <= raw_code;
      end else if (ctrl.shift) begin
        code <= shift_in;
      end else if (ctrl.blank && CanBlank && zero_above_in && is_zero) begin
        code <= BLANK_CODE;
      end
    end
  end

endmodule

/* rtl/core/ssd_bcd_step.sv */
// Binary to decimal digit generator: one divide-by-ten step per cycle.
`timescale 1ns / 1ps
module ssd_bcd_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] value,
  output logic        shift,
  output logic        last,
  output logic [3:0]  digit
);
  import ssd_pkg::*;

  logic [15:0] work;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] tenq;
  logic [15:0] rem;

  assign prod  = work * DIV10_MUL;
  assign quot  = prod[31:DIV10_SHIFT];
  assign tenq  = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem   = work - tenq;
  assign digit = rem[3:0];
  assign shift = busy;
  assign last  = busy && (cnt == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= value;
    end else if (busy) begin
      work <= {3'b000, quot};
    end
  end

endmodule

/* tb/sv/tb_seven_segment_scan_with_bcd.sv */
// Self-checking testbench for the four-digit multiplexed display driver.
`timescale 1ns / 1ps
module tb_seven_segment_scan_with_bcd;
  import ssd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;  // not decoded by the block
  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_WAIT     = 17;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 150;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    bit          drain;   // hold this item back until every result is in
    logic [1:0]  mode;
    logic [31:0] codes;   // digit_d, digit_c, digit_b, digit_a
    logic [15:0] value;
  } disp_item_t;

  typedef struct packed {
    logic [7:0] port_value;
    logic       updated;
  } port_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;

  disp_item_t   disp_item_q [$];
  port_result_t port_expect_q [$];

  // shadow copy of the display state
  logic [7:0] shadow_codes [DIGITS] = RESET_CODES;
  logic [1:0] shadow_scan  = '0;
  logic [7:0] shadow_latch = '0;

  int n_items   = 0;
  int n_sent    = 0;
  int n_results = 0;
  int n_errors  = 0;
  int idle_cycles = 0;

  seven_segment_scan_with_bcd dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch on result %0d: %s = 0x%02h, expected 0x%02h",
             n_results, field, got, want);
    n_errors++;
  endtask

  task automatic push_item(logic [1:0] mode, logic [15:0] value, logic [31:0] codes,
                           bit drain);
    disp_item_t it;
    it.drain = drain;
    it.mode  = mode;
    it.codes = codes;
    it.value = value;
    disp_item_q.push_back(it);
    n_items++;
  endtask

  // Advances the shadow state by one accepted item; a tick queues its port result.
  function automatic void predict_display(disp_item_t it);
    logic [7:0]   code;
    logic [7:0]   port_byte;
    logic [15:0]  rem;
    bit           lead;
    port_result_t res;
    case (it.mode)
      MODE_RAW: begin
        for (int i = 0; i < DIGITS; i++) shadow_codes[i] = it.codes[8*i +: 8];
      end
      MODE_BIN: begin
        rem = it.value;
        for (int i = 0; i < DIGITS; i++) begin
          shadow_codes[i] = 8'(rem % 10);
          rem = 16'(rem / 10);
        end
        // blank leading zeros from the top, never the ones digit
        lead = 1'b1;
        for (int i = DIGITS - 1; i >= 1; i--) begin
          if (lead && shadow_codes[i] == 8'd0) shadow_codes[i] = BLANK_CODE;
          else lead = 1'b0;
        end
      end
      MODE_TICK: begin
        code = shadow_codes[shadow_scan];
        port_byte = {4'(1 << shadow_scan), code[3:0]};
        if (code < CODE_LIMIT) shadow_latch = port_byte;
        res.port_value = shadow_latch;
        res.updated = (code < CODE_LIMIT);
        port_expect_q.push_back(res);
        shadow_scan = shadow_scan + 2'd1;
      end
      default: ;
    endcase
  endfunction

  // driver: one transfer per queued item, random gap after each
  int         src_wait = 0;
  int         src_calm = 0;
  disp_item_t in_flight;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_display(in_flight);
        n_sent++;
        if (src_calm > 0) begin
          src_calm--;
          src_wait = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) src_calm = $urandom_range(20, 60);
          src_wait = $urandom_range(0, MAX_WAIT);
        end
      end
      if (src_wait > 0) begin
        src_wait--;
        s_tvalid <= 1'b0;
      end else if (disp_item_q.size() > 0 &&
                   !(disp_item_q[0].drain && port_expect_q.size() > 0)) begin
        in_flight = disp_item_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {in_flight.codes, in_flight.value};
        s_tuser  <= in_flight.mode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compares each port transfer against the oldest prediction
  int           sink_wait = 0;
  int           sink_calm = 0;
  port_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (port_expect_q.size() == 0) begin
          $display("unexpected result %0d: port_value = 0x%02h", n_results, m_tdata);
          n_errors++;
        end else begin
          want = port_expect_q.pop_front();
          if (m_tdata !== want.port_value)
            report_mismatch("port_value", m_tdata, want.port_value);
          if (m_tuser[0] !== want.updated)
            report_mismatch("port_updated", {7'd0, m_tuser[0]}, {7'd0, want.updated});
        end
        // long hold-off lets the block back up into its input
        if (n_results % 600 == 300) begin
          sink_wait = HOLD_CYCLES;
        end else if (sink_calm > 0) begin
          sink_calm--;
          sink_wait = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) sink_calm = $urandom_range(20, 60);
          sink_wait = $urandom_range(0, MAX_WAIT);
        end
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          n_random;
    int          next_drain;
    int          n_ticks;
    logic [15:0] bin_value;
    logic [31:0] raw_codes;

    // directed: reset codes, raw extremes, blanking, truncation, unused mode
    repeat (4) push_item(MODE_TICK, 16'($urandom), $urandom, 1'b0);
    push_item(MODE_RAW, 16'($urandom), {8'd255, 8'd10, 8'd9, 8'd0}, 1'b0);
    repeat (4) push_item(MODE_TICK, 16'($urandom), $urandom, 1'b0);
    push_item(MODE_BIN, 16'd0, $urandom, 1'b0);
    repeat (2) push_item(MODE_TICK, 16'($urandom), $urandom, 1'b0);
    push_item(MODE_BIN, 16'd10000, $urandom, 1'b0);
    repeat (2) push_item(MODE_TICK, 16'($urandom), $urandom, 1'b0);
    push_item(MODE_BIN, 16'd65535, $urandom, 1'b0);
    push_item(MODE_UNUSED, 16'($urandom), $urandom, 1'b0);
    repeat (4) push_item(MODE_TICK, 16'($urandom), $urandom, 1'b0);
    push_item(MODE_BIN, 16'd1000, $urandom, 1'b0);
    repeat (4) push_item(MODE_TICK, 16'($urandom), $urandom, 1'b1);

    // random: mostly a load followed by a run of ticks
    n_random = 0;
    next_drain = 500;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          if ($urandom_range(0, 2) == 0) begin
            for (int i = 0; i < DIGITS; i++) begin
              case ($urandom_range(0, 5))
                4:       raw_codes[8*i +: 8] = 8'($urandom_range(10, 15));
                5:       raw_codes[8*i +: 8] = 8'($urandom_range(0, 255));
                default: raw_codes[8*i +: 8] = 8'($urandom_range(0, 9));
              endcase
            end
            push_item(MODE_RAW, 16'($urandom), raw_codes, n_random >= next_drain);
          end else begin
            case ($urandom_range(0, 4))
              0:       bin_value = 16'($urandom_range(0, 65535));
              1:       bin_value = 16'($urandom_range(0, 9));
              2:       bin_value = 16'($urandom_range(0, 99));
              3:       bin_value = 16'($urandom_range(0, 999));
              default: bin_value = 16'(10000 * $urandom_range(0, 6) + $urandom_range(0, 9));
            endcase
            push_item(MODE_BIN, bin_value, $urandom, n_random >= next_drain);
          end
          if (n_random >= next_drain) next_drain += 600;
          n_random++;
          n_ticks = $urandom_range(1, 8);
          repeat (n_ticks) push_item(MODE_TICK, 16'($urandom), $urandom, 1'b0);
          n_random += n_ticks;
        end
        2: begin
          n_ticks = $urandom_range(1, 6);
          repeat (n_ticks) push_item(MODE_TICK, 16'($urandom), $urandom, 1'b0);
          n_random += n_ticks;
        end
        default: begin
          // noise: ignored mode, or a binary load with no ticks of its own
          if ($urandom_range(0, 1) == 0) begin
            push_item(MODE_UNUSED, 16'($urandom), $urandom, 1'b0);
          end else begin
            push_item(MODE_BIN, 16'($urandom), $urandom, 1'b0);
            n_random++;
          end
        end
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (n_sent < n_items || port_expect_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
